### rtl/fesfe_pkg.sv
// fesfe_pkg: constants, types and arithmetic helpers for the shape function evaluator
// no dependencies; used by fe_shape_function_evaluator_unit and fesfe_checker
package fesfe_pkg;

    localparam int FRAC_BITS = 16;
    localparam int OUT_W     = 20;
    localparam int MW        = FRAC_BITS + 16;
    localparam int OPW       = FRAC_BITS + 8;
    localparam int PW        = MW + OPW;
    localparam int SW        = MW + 4;
    localparam int COORD_W   = 18;
    localparam int NODE_W    = 5;
    localparam int CMD_W     = 3;
    localparam int ADDR_W    = 3;

    localparam longint ONE     = longint'(1) << FRAC_BITS;
    localparam longint HALF    = longint'(1) << (FRAC_BITS - 1);
    localparam longint SAT_HI  = (4 * ONE > 524287) ? 524287 : 4 * ONE;
    localparam longint SAT_LO  = (-4 * ONE < -524288) ? -524288 : -4 * ONE;

    localparam logic [CMD_W-1:0] CMD_HEX8  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_HEX20 = 3'd1;
    localparam logic [CMD_W-1:0] CMD_HEX27 = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TET4  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TET10 = 3'd4;

    localparam logic [0:0] REG_DERIV_EN = 1'b0;

    localparam logic [1:0] XM = 2'b11;
    localparam logic [1:0] XZ = 2'b00;
    localparam logic [1:0] XP = 2'b01;

    // natural position per hex node, {r, s, t}, each -1/0/+1
    localparam logic [5:0] HEX_POS [0:26] = '{
        {XM, XM, XM}, {XP, XM, XM}, {XP, XP, XM}, {XM, XP, XM},
        {XM, XM, XP}, {XP, XM, XP}, {XP, XP, XP}, {XM, XP, XP},
        {XZ, XM, XM}, {XP, XZ, XM}, {XZ, XP, XM}, {XM, XZ, XM},
        {XM, XM, XZ}, {XP, XM, XZ}, {XP, XP, XZ}, {XM, XP, XZ},
        {XZ, XM, XP}, {XP, XZ, XP}, {XZ, XP, XP}, {XM, XZ, XP},
        {XZ, XZ, XM}, {XZ, XM, XZ}, {XP, XZ, XZ}, {XZ, XP, XZ},
        {XM, XZ, XZ}, {XZ, XZ, XP}, {XZ, XZ, XZ}
    };

    typedef struct packed {
        logic              valid;
        logic [NODE_W-1:0] node;
        logic              last;
        logic              err;
        logic [CMD_W-1:0]  cmd;
    } ctl_t;

    function automatic logic [5:0] hex_pos(input logic [NODE_W-1:0] node);
        logic [5:0] pos;
        pos = 6'd0;
        if (node <= NODE_W'(26))
        begin
            pos = HEX_POS[node];
        end
        return pos;
    endfunction

    function automatic logic [NODE_W-1:0] last_index(input logic [CMD_W-1:0] cmd);
        logic [NODE_W-1:0] idx;
        unique case (cmd)
            CMD_HEX8:  idx = NODE_W'(7);
            CMD_HEX20: idx = NODE_W'(19);
            CMD_HEX27: idx = NODE_W'(26);
            CMD_TET4:  idx = NODE_W'(3);
            CMD_TET10: idx = NODE_W'(9);
            default:   idx = NODE_W'(0);
        endcase
        return idx;
    endfunction

    // product with round half up
    function automatic logic signed [MW-1:0] fmul(input logic signed [MW-1:0] a,
                                                  input logic signed [OPW-1:0] b);
        logic signed [PW-1:0] p;
        p = PW'(a) * PW'(b);
        p = p + PW'(HALF);
        return MW'(p >>> FRAC_BITS);
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SW-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > SW'(SAT_HI))
        begin
            r = OUT_W'(SAT_HI);
        end
        else if (v < SW'(SAT_LO))
        begin
            r = OUT_W'(SAT_LO);
        end
        else
        begin
            r = OUT_W'(v);
        end
        return r;
    endfunction

endpackage

### rtl/fe_shape_function_evaluator_unit.sv
// fe_shape_function_evaluator_unit: hex8/hex20/hex27/tet4/tet10 shape functions per node
// depends on fesfe_pkg
//
// A request (command, coord_r/s/t) is taken when start is high and busy is low. The
// sequencer then issues one node per cycle, so a request issues as many nodes as its
// element has (8, 20, 27, 4 or 10; one for an unknown type), and the next request
// is taken in the cycle the last node issues. Each node runs through a six-stage pipeline
// (issue, axis factors, three multiply stages, scale and saturate) and appears on the
// result ports for one cycle with valid high; results cannot be held off.
// derivatives_enable sits at APB address 0 and should only change while no request is in flight.
module fe_shape_function_evaluator_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [fesfe_pkg::CMD_W-1:0]          command,
    input  logic signed [fesfe_pkg::COORD_W-1:0] coord_r,
    input  logic signed [fesfe_pkg::COORD_W-1:0] coord_s,
    input  logic signed [fesfe_pkg::COORD_W-1:0] coord_t,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [fesfe_pkg::ADDR_W-1:0]         paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    output logic                                 valid,
    output logic [fesfe_pkg::NODE_W-1:0]         node_index,
    output logic signed [fesfe_pkg::OUT_W-1:0]   shape_value,
    output logic signed [fesfe_pkg::OUT_W-1:0]   d_r,
    output logic signed [fesfe_pkg::OUT_W-1:0]   d_s,
    output logic signed [fesfe_pkg::OUT_W-1:0]   d_t,
    output logic                                 last_node,
    output logic                                 type_error
);

    localparam int MW  = fesfe_pkg::MW;
    localparam int OPW = fesfe_pkg::OPW;
    localparam int SW  = fesfe_pkg::SW;
    localparam int NW  = fesfe_pkg::NODE_W;
    localparam logic signed [OPW-1:0] ONE_OP = OPW'(fesfe_pkg::ONE);

    // configuration
    logic deriv_en_reg;
    logic cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[fesfe_pkg::ADDR_W-1] == fesfe_pkg::REG_DERIV_EN) ?
                       {31'd0, deriv_en_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deriv_en_reg <= 1'b1;
        end
        else if (cfg_write && paddr[fesfe_pkg::ADDR_W-1] == fesfe_pkg::REG_DERIV_EN)
        begin
            deriv_en_reg <= pwdata[0];
        end
    end

    // sequencer
    logic                               active_reg;
    logic [NW-1:0]                      node_reg;
    logic [NW-1:0]                      last_idx_reg;
    logic [fesfe_pkg::CMD_W-1:0]        cmd_reg;
    logic signed [fesfe_pkg::COORD_W-1:0] x_reg [0:2];
    logic                               on_last;
    logic                               accept;

    assign on_last = (node_reg == last_idx_reg);
    assign busy    = active_reg && !on_last;
    assign accept  = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            node_reg   <= '0;
            last_idx_reg <= '0;
            cmd_reg    <= '0;
        end
        else if (accept)
        begin
            active_reg   <= 1'b1;
            node_reg     <= '0;
            last_idx_reg <= fesfe_pkg::last_index(command);
            cmd_reg      <= command;
        end
        else if (active_reg && on_last)
        begin
            active_reg <= 1'b0;
        end
        else if (active_reg)
        begin
            node_reg <= node_reg + NW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg[0] <= coord_r;
            x_reg[1] <= coord_s;
            x_reg[2] <= coord_t;
        end
    end

    fesfe_pkg::ctl_t s0_ctl;
    assign s0_ctl.valid = active_reg;
    assign s0_ctl.node  = node_reg;
    assign s0_ctl.last  = on_last;
    assign s0_ctl.err   = (cmd_reg > fesfe_pkg::CMD_TET10);
    assign s0_ctl.cmd   = cmd_reg;

    // stage 1: axis factors and tet terms
    logic signed [OPW-1:0] f_next [0:2];
    logic signed [OPW-1:0] g_next [0:2];
    logic signed [OPW-1:0] tp_next, tq_next;
    logic signed [OPW-1:0] td_next [0:2];
    logic [5:0]            pos_next;

    always_comb
    begin
        logic                  lag;
        logic signed [1:0]     xi;
        logic signed [OPW-1:0] xe, xs, ma, mb;
        logic signed [MW-1:0]  prod;
        lag      = (cmd_reg == fesfe_pkg::CMD_HEX27);
        pos_next = fesfe_pkg::hex_pos(node_reg);
        for (int i = 0; i < 3; i++)
        begin
            xi = pos_next[5-2*i -: 2];
            xe = OPW'(x_reg[i]);
            xs = (xi < 0) ? -xe : xe;
            if (lag && xi == 2'sd0)
            begin
                ma = ONE_OP - xe;
                mb = ONE_OP + xe;
            end
            else if (lag)
            begin
                ma = xe;
                mb = ONE_OP + xs;
            end
            else
            begin
                ma = xe;
                mb = xe;
            end
            prod = fesfe_pkg::fmul(MW'(ma), mb);
            if (lag)
            begin
                f_next[i] = OPW'(prod);
            end
            else if (xi == 2'sd0)
            begin
                f_next[i] = OPW'(MW'(ONE_OP) - prod);
            end
            else
            begin
                f_next[i] = ONE_OP + xs;
            end
            if (xi == 2'sd0)
            begin
                g_next[i] = xe;
            end
            else if (lag)
            begin
                g_next[i] = ONE_OP + (xs <<< 1);
            end
            else
            begin
                g_next[i] = ONE_OP;
            end
        end
    end

    always_comb
    begin
        logic signed [OPW-1:0] r, s, t, u, r4, s4, t4, u4, xn;
        r  = OPW'(x_reg[0]);
        s  = OPW'(x_reg[1]);
        t  = OPW'(x_reg[2]);
        u  = ONE_OP - r - s - t;
        r4 = r <<< 2;
        s4 = s <<< 2;
        t4 = t <<< 2;
        u4 = u <<< 2;
        xn = (node_reg[1:0] == 2'd0) ? r : ((node_reg[1:0] == 2'd1) ? s : t);
        tp_next    = '0;
        tq_next    = ONE_OP;
        td_next[0] = '0;
        td_next[1] = '0;
        td_next[2] = '0;
        if (cmd_reg == fesfe_pkg::CMD_TET4)
        begin
            if (node_reg < NW'(3))
            begin
                tp_next = xn;
                td_next[node_reg[1:0]] = ONE_OP;
            end
            else
            begin
                tp_next    = u;
                td_next[0] = -ONE_OP;
                td_next[1] = -ONE_OP;
                td_next[2] = -ONE_OP;
            end
        end
        else
        begin
            unique case (node_reg)
                NW'(0), NW'(1), NW'(2):
                begin
                    tp_next = xn;
                    tq_next = (xn <<< 1) - ONE_OP;
                    td_next[node_reg[1:0]] = (xn <<< 2) - ONE_OP;
                end
                NW'(3):
                begin
                    tp_next    = u;
                    tq_next    = (u <<< 1) - ONE_OP;
                    td_next[0] = ONE_OP - u4;
                    td_next[1] = ONE_OP - u4;
                    td_next[2] = ONE_OP - u4;
                end
                NW'(4):
                begin
                    tp_next = r4; tq_next = s; td_next[0] = s4; td_next[1] = r4;
                end
                NW'(5):
                begin
                    tp_next = s4; tq_next = t; td_next[1] = t4; td_next[2] = s4;
                end
                NW'(6):
                begin
                    tp_next = r4; tq_next = t; td_next[0] = t4; td_next[2] = r4;
                end
                NW'(7):
                begin
                    tp_next = r4; tq_next = u;
                    td_next[0] = u4 - r4; td_next[1] = -r4; td_next[2] = -r4;
                end
                NW'(8):
                begin
                    tp_next = s4; tq_next = u;
                    td_next[0] = -s4; td_next[1] = u4 - s4; td_next[2] = -s4;
                end
                default:
                begin
                    tp_next = t4; tq_next = u;
                    td_next[0] = -t4; td_next[1] = -t4; td_next[2] = u4 - t4;
                end
            endcase
        end
    end

    fesfe_pkg::ctl_t       s1_ctl_reg;
    logic signed [OPW-1:0] f_reg [0:2];
    logic signed [OPW-1:0] g_reg [0:2];
    logic signed [OPW-1:0] tp_reg, tq_reg;
    logic signed [OPW-1:0] td_reg [0:2];
    logic [5:0]            pos_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            f_reg[i]  <= f_next[i];
            g_reg[i]  <= g_next[i];
            td_reg[i] <= td_next[i];
        end
        tp_reg  <= tp_next;
        tq_reg  <= tq_next;
        pos_reg <= pos_next;
    end

    // stage 2: operand select per lane, first multiply
    logic signed [MW-1:0]  m1_next [0:3];
    logic signed [OPW-1:0] c_next [0:3];
    logic signed [OPW-1:0] dd_next [0:3];
    logic                  neg_next [0:3];
    logic signed [2:0]     ex_next [0:3];

    always_comb
    begin
        logic                  lag, corner, tet, use_g, tneg;
        logic signed [1:0]     xi;
        logic signed [2:0]     tex;
        logic signed [OPW-1:0] sum, op_a, op_b, tv;
        logic signed [OPW-1:0] trm [0:2];
        lag    = (s1_ctl_reg.cmd == fesfe_pkg::CMD_HEX27);
        corner = (s1_ctl_reg.cmd == fesfe_pkg::CMD_HEX20) && (s1_ctl_reg.node < NW'(8));
        tet    = (s1_ctl_reg.cmd == fesfe_pkg::CMD_TET4) ||
                 (s1_ctl_reg.cmd == fesfe_pkg::CMD_TET10);
        sum    = f_reg[0] + f_reg[1] + f_reg[2] - (ONE_OP <<< 2) - ONE_OP;
        for (int k = 0; k < 4; k++)
        begin
            neg_next[k] = 1'b0;
            ex_next[k]  = 3'sd0;
            c_next[k]   = ONE_OP;
            dd_next[k]  = ONE_OP;
            op_a        = ONE_OP;
            op_b        = ONE_OP;
            for (int e = 0; e < 3; e++)
            begin
                xi     = pos_reg[5-2*e -: 2];
                use_g  = (k == e + 1);
                if (use_g)
                begin
                    tv   = g_reg[e];
                    tneg = (xi == 2'sd0) ? 1'b1 : (xi < 0);
                    tex  = (xi == 2'sd0) ? 3'sd1 : -3'sd1;
                end
                else
                begin
                    tv   = f_reg[e];
                    tneg = lag && (xi < 0);
                    tex  = (xi == 2'sd0) ? 3'sd0 : -3'sd1;
                end
                trm[e] = tv;
                if (!tet && !corner)
                begin
                    neg_next[k] = neg_next[k] ^ tneg;
                    ex_next[k]  = ex_next[k] + tex;
                end
            end
            if (tet)
            begin
                op_a = (k == 0) ? tp_reg : td_reg[(k == 0) ? 0 : k - 1];
                op_b = (k == 0) ? tq_reg : ONE_OP;
            end
            else if (corner)
            begin
                ex_next[k] = -3'sd3;
                if (k == 0)
                begin
                    op_a       = f_reg[0];
                    op_b       = f_reg[1];
                    c_next[k]  = f_reg[2];
                    dd_next[k] = sum;
                end
                else
                begin
                    xi          = pos_reg[5-2*(k-1) -: 2];
                    neg_next[k] = (xi < 0);
                    op_a        = (k == 1) ? f_reg[1] : f_reg[0];
                    op_b        = (k == 3) ? f_reg[1] : f_reg[2];
                    c_next[k]   = sum + f_reg[k-1];
                end
            end
            else
            begin
                op_a      = trm[0];
                op_b      = trm[1];
                c_next[k] = trm[2];
            end
            m1_next[k] = fesfe_pkg::fmul(MW'(op_a), op_b);
        end
    end

    fesfe_pkg::ctl_t       s2_ctl_reg, s3_ctl_reg, s4_ctl_reg;
    logic signed [MW-1:0]  m1_reg [0:3];
    logic signed [MW-1:0]  m2_reg [0:3];
    logic signed [MW-1:0]  m3_reg [0:3];
    logic signed [OPW-1:0] c_reg [0:3];
    logic signed [OPW-1:0] dd2_reg [0:3];
    logic signed [OPW-1:0] dd3_reg [0:3];
    logic                  neg2_reg [0:3];
    logic                  neg3_reg [0:3];
    logic                  neg4_reg [0:3];
    logic signed [2:0]     ex2_reg [0:3];
    logic signed [2:0]     ex3_reg [0:3];
    logic signed [2:0]     ex4_reg [0:3];

    // stages 3 and 4: remaining multiplies
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            m1_reg[k]   <= m1_next[k];
            c_reg[k]    <= c_next[k];
            dd2_reg[k]  <= dd_next[k];
            neg2_reg[k] <= neg_next[k];
            ex2_reg[k]  <= ex_next[k];
            m2_reg[k]   <= fesfe_pkg::fmul(m1_reg[k], c_reg[k]);
            dd3_reg[k]  <= dd2_reg[k];
            neg3_reg[k] <= neg2_reg[k];
            ex3_reg[k]  <= ex2_reg[k];
            m3_reg[k]   <= fesfe_pkg::fmul(m2_reg[k], dd3_reg[k]);
            neg4_reg[k] <= neg3_reg[k];
            ex4_reg[k]  <= ex3_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            s3_ctl_reg <= '0;
            s4_ctl_reg <= '0;
        end
        else
        begin
            s1_ctl_reg <= s0_ctl;
            s2_ctl_reg <= s1_ctl_reg;
            s3_ctl_reg <= s2_ctl_reg;
            s4_ctl_reg <= s3_ctl_reg;
        end
    end

    // stage 5: power of two, sign, saturation
    logic signed [fesfe_pkg::OUT_W-1:0] res_next [0:3];

    always_comb
    begin
        logic signed [SW-1:0] v;
        for (int k = 0; k < 4; k++)
        begin
            v = SW'(m3_reg[k]);
            unique case (ex4_reg[k])
                -3'sd3:  v = (v + SW'(4)) >>> 3;
                -3'sd2:  v = (v + SW'(2)) >>> 2;
                -3'sd1:  v = (v + SW'(1)) >>> 1;
                3'sd0:   v = v;
                3'sd1:   v = v <<< 1;
                3'sd2:   v = v <<< 2;
                3'sd3:   v = v <<< 3;
                default: v = '0;
            endcase
            if (neg4_reg[k])
            begin
                v = -v;
            end
            res_next[k] = fesfe_pkg::sat_out(v);
            if (s4_ctl_reg.err || (k != 0 && !deriv_en_reg))
            begin
                res_next[k] = '0;
            end
        end
    end

    logic                               valid_reg;
    logic [NW-1:0]                      node_index_reg;
    logic signed [fesfe_pkg::OUT_W-1:0] res_reg [0:3];
    logic                               last_reg;
    logic                               err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= s4_ctl_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        node_index_reg <= s4_ctl_reg.node;
        last_reg       <= s4_ctl_reg.last;
        err_reg        <= s4_ctl_reg.err;
        for (int k = 0; k < 4; k++)
        begin
            res_reg[k] <= res_next[k];
        end
    end

    assign valid       = valid_reg;
    assign node_index  = node_index_reg;
    assign shape_value = res_reg[0];
    assign d_r         = res_reg[1];
    assign d_s         = res_reg[2];
    assign d_t         = res_reg[3];
    assign last_node   = last_reg;
    assign type_error  = err_reg;

endmodule

### rtl/fesfe_checker.sv
// fesfe_checker: port-level assertions on the result stream, bound to the top level
// depends on fesfe_pkg and fe_shape_function_evaluator_unit
module fesfe_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               valid,
    input logic [fesfe_pkg::NODE_W-1:0]       node_index,
    input logic signed [fesfe_pkg::OUT_W-1:0] shape_value,
    input logic signed [fesfe_pkg::OUT_W-1:0] d_r,
    input logic signed [fesfe_pkg::OUT_W-1:0] d_s,
    input logic signed [fesfe_pkg::OUT_W-1:0] d_t,
    input logic                               last_node,
    input logic                               type_error
);

    // nodes of one request come back to back
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !last_node |=> valid)
        else $error("result stream broke before last node");

    a_node_step: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !last_node |=> node_index == $past(node_index) + 5'd1)
        else $error("node index not ascending by one");

    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        valid && type_error |-> last_node && node_index == 5'd0 && shape_value == '0 &&
        d_r == '0 && d_s == '0 && d_t == '0)
        else $error("bad type error result");

    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        valid && last_node && !type_error |-> node_index == 5'd7 || node_index == 5'd19 ||
        node_index == 5'd26 || node_index == 5'd3 || node_index == 5'd9)
        else $error("last node index does not match an element size");

endmodule

bind fe_shape_function_evaluator_unit fesfe_checker u_fesfe_checker (.*);
